>>> sv/czvd_pkg.sv
package czvd_pkg;

	localparam logic MODE_REG = 1'b0;
	localparam logic MODE_TAX = 1'b1;

	localparam logic [3:0] KEPT_SAT  = 4'd13;
	localparam logic [3:0] DIGIT_SAT = 4'd9;
	localparam logic [3:0] LAST_WEIGHTED = 4'd7;
	localparam logic [3:0] CHECK_POS = 4'd8;
	localparam logic [3:0] TOP_WEIGHT = 4'd8;
	localparam logic [3:0] KEPT_MIN = 4'd10;
	localparam logic [3:0] KEPT_MAX = 4'd12;
	localparam logic [6:0] MODULUS = 7'd11;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_C  = 8'h43;
	localparam logic [7:0] CH_LC_C  = 8'h63;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// classified character handed from front to back
	typedef struct packed {
		logic       mode;
		logic       last;
		logic       keep;
		logic       digit;
		logic [3:0] dval;
		logic       is_c;
		logic       is_z;
	} tok_t;

	// residue mod 11 of a value up to 82
	function automatic logic [3:0] mod11(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		// fold out 44, then 22, then 11
		if (r >= (MODULUS << 2)) begin
			r = r - (MODULUS << 2);
		end
		if (r >= (MODULUS << 1)) begin
			r = r - (MODULUS << 1);
		end
		if (r >= MODULUS) begin
			r = r - MODULUS;
		end
		return r[3:0];
	endfunction

endpackage

>>> sv/czvd_front.sv
module czvd_front
	import czvd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       action,
	input  logic       last,
	output logic       push,
	output tok_t       push_tok,
	input  logic       q_full
);

	logic in_str_q;
	logic mode_q;
	logic mode_cur;

	assign in_ready = !q_full;
	assign push = in_valid && in_ready;
	assign mode_cur = in_str_q ? mode_q : action;

	always_comb begin
		push_tok.mode  = mode_cur;
		push_tok.last  = last;
		push_tok.digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		push_tok.dval  = 4'(char_code - CH_ZERO);
		push_tok.keep  = !(((char_code >= CH_TAB) && (char_code <= CH_CR))
			|| (char_code == CH_SPACE) || (char_code == CH_DASH) || (char_code == CH_DOT));
		push_tok.is_c  = (char_code == CH_UC_C) || (char_code == CH_LC_C);
		push_tok.is_z  = (char_code == CH_UC_Z) || (char_code == CH_LC_Z);
	end

	// latch mode on the first character of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_str_q <= 1'b0;
			mode_q <= MODE_REG;
		end else if (push) begin
			in_str_q <= !last;
			mode_q <= mode_cur;
		end
	end

endmodule

>>> sv/czvd_fifo.sv
module czvd_fifo
	import czvd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	output logic tok_valid,
	output tok_t tok,
	input  logic pop
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tok_t            mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok = mem_q[rd_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/czvd_back.sv
module czvd_back
	import czvd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic tok_valid,
	input  tok_t tok,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output logic valid_res
);

	logic [3:0] kept_q;
	logic [3:0] dcnt_q;
	logic [3:0] rsum_q;
	logic [3:0] chk_q;
	logic       pbad_q;
	logic       bbad_q;
	logic       oval_q;
	logic       res_q;

	logic       tax_keep;
	logic       body_pos;
	logic       take;
	logic [3:0] wt;
	logic [6:0] prod;
	logic [3:0] kept_n;
	logic [3:0] dcnt_n;
	logic [3:0] rsum_n;
	logic [3:0] chk_n;
	logic       pbad_n;
	logic       bbad_n;
	logic [3:0] expect_d;
	logic       sum_ok;
	logic       ok;

	// hold the token while a finished result is still waiting
	assign pop = tok_valid && (!tok.last || !oval_q || out_ready);
	assign out_valid = oval_q;
	assign valid_res = res_q;

	always_comb begin
		tax_keep = (tok.mode == MODE_TAX) && tok.keep;
		body_pos = kept_q >= 4'd2;
		take = tok.digit && ((tok.mode == MODE_REG) || (tax_keep && body_pos));
		wt = TOP_WEIGHT - dcnt_q;
		prod = 7'(tok.dval * wt);

		rsum_n = (take && dcnt_q < LAST_WEIGHTED) ? mod11(7'(rsum_q) + prod) : rsum_q;
		chk_n = (take && dcnt_q == LAST_WEIGHTED) ? tok.dval : chk_q;
		dcnt_n = (take && dcnt_q < DIGIT_SAT) ? dcnt_q + 4'd1 : dcnt_q;
		kept_n = (tax_keep && kept_q < KEPT_SAT) ? kept_q + 4'd1 : kept_q;
		pbad_n = pbad_q || (tax_keep && (((kept_q == 4'd0) && !tok.is_c)
			|| ((kept_q == 4'd1) && !tok.is_z)));
		bbad_n = bbad_q || (tax_keep && body_pos && !tok.digit);

		case (rsum_n)
			4'd0: expect_d = 4'd1;
			4'd1: expect_d = 4'd0;
			default: expect_d = 4'(MODULUS) - rsum_n;
		endcase
		sum_ok = (dcnt_n == CHECK_POS) && (expect_d == chk_n);

		if (tok.mode == MODE_REG) begin
			ok = sum_ok;
		end else begin
			ok = (kept_n >= KEPT_MIN) && (kept_n <= KEPT_MAX) && !pbad_n && !bbad_n
				&& ((kept_n != KEPT_MIN) || sum_ok);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
			dcnt_q <= '0;
			rsum_q <= '0;
			chk_q <= '0;
			pbad_q <= 1'b0;
			bbad_q <= 1'b0;
			oval_q <= 1'b0;
			res_q <= 1'b0;
		end else begin
			if (oval_q && out_ready && !(pop && tok.last)) begin
				oval_q <= 1'b0;
			end
			if (pop) begin
				if (tok.last) begin
					// drop string state, post the verdict
					kept_q <= '0;
					dcnt_q <= '0;
					rsum_q <= '0;
					chk_q <= '0;
					pbad_q <= 1'b0;
					bbad_q <= 1'b0;
					oval_q <= 1'b1;
					res_q <= ok;
				end else begin
					kept_q <= kept_n;
					dcnt_q <= dcnt_n;
					rsum_q <= rsum_n;
					chk_q <= chk_n;
					pbad_q <= pbad_n;
					bbad_q <= bbad_n;
				end
			end
		end
	end

endmodule

>>> sv/czech_tax_id_check_digit_validator.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  char_code[7:0], action, last
// result    out        out_valid/out_ready  valid_res
//
// One character per cycle is taken when the token queue has room.
// A character is written into the queue when it is transferred and is folded
// into the checksum as it leaves the queue; the verdict is registered as the
// final character leaves and is held until out_ready takes it.
// Reset clears all string state, the queue and the result register.
// A stalled result holds only a final character in the queue; other characters
// keep flowing until the queue fills.
module czech_tax_id_check_digit_validator
	import czvd_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       action,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       valid_res
);

	logic push;
	tok_t push_tok;
	logic q_full;
	logic tok_valid;
	tok_t tok;
	logic pop;

	czvd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_code(char_code),
		.action   (action),
		.last     (last),
		.push     (push),
		.push_tok (push_tok),
		.q_full   (q_full)
	);

	czvd_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.tok_valid(tok_valid),
		.tok      (tok),
		.pop      (pop)
	);

	czvd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok      (tok),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.valid_res(valid_res)
	);

	a_last_posts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.last |=> out_valid)
		else $error("final character popped without a result");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> tok_valid)
		else $error("queue empty after a transfer in");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && tok_valid && tok.last |-> !pop)
		else $error("pending result overwritten");

endmodule
